FILE: rtl/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg
// Shared constants, types and lookup functions of the entity and UTF-8
// text decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

    localparam int MAX_NAME  = 10;
    localparam int HOLD      = MAX_NAME + 1;
    localparam int WORK      = HOLD + 1;
    localparam int IDX_W     = $clog2(WORK + 1);
    localparam int NUM_NAMES = 9;
    localparam int NAME_IDX_W = $clog2(NUM_NAMES);

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_SCAN,
        ST_DOT1,
        ST_DOT2,
        ST_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        ES_HEAD,
        ES_AMP,
        ES_ENT,
        ES_DOT
    } t_esel;

    typedef enum logic [1:0] {
        DR_NONE,
        DR_NEED,
        DR_ONE,
        DR_ENT
    } t_drop;

    typedef struct packed {
        logic  load;
        logic  scan_init;
        logic  scan_step;
        logic  emit;
        t_esel esel;
        t_drop drop;
        logic  flush;
    } t_cmd;

    typedef struct packed {
        logic len_zero;
        logic head_amp;
        logic hold_utf;
        logic scan_out;
        logic scan_term;
        logic ent_hit;
        logic ent_hellip;
        logic run_end;
        logic emit_ok;
        logic out_free;
        logic pend_valid;
    } t_stat;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_stop(input logic [7:0] c);
        return c == 8'h3C || c == 8'h20 || c == 8'h09 || c == 8'h0A ||
               c == 8'h0D || c == 8'h0C || c == 8'h0B;
    endfunction

    // named entity table, text right-aligned
    function automatic logic [47:0] name_str(input logic [NAME_IDX_W-1:0] k);
        logic [47:0] s;
        unique case (k)
            4'd0:    s = 48'("amp");
            4'd1:    s = 48'("lt");
            4'd2:    s = 48'("gt");
            4'd3:    s = 48'("quot");
            4'd4:    s = 48'("apos");
            4'd5:    s = 48'("nbsp");
            4'd6:    s = 48'("mdash");
            4'd7:    s = 48'("ndash");
            4'd8:    s = 48'("hellip");
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [IDX_W-1:0] name_len(input logic [NAME_IDX_W-1:0] k);
        logic [IDX_W-1:0] l;
        unique case (k)
            4'd0:    l = 4'd3;
            4'd1:    l = 4'd2;
            4'd2:    l = 4'd2;
            4'd3:    l = 4'd4;
            4'd4:    l = 4'd4;
            4'd5:    l = 4'd4;
            4'd6:    l = 4'd5;
            4'd7:    l = 4'd5;
            4'd8:    l = 4'd6;
            default: l = '0;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] name_val(input logic [NAME_IDX_W-1:0] k);
        logic [7:0] v;
        unique case (k)
            4'd0:    v = CH_AMP;
            4'd1:    v = 8'h3C;
            4'd2:    v = 8'h3E;
            4'd3:    v = CH_QUOTE;
            4'd4:    v = CH_APOS;
            4'd5:    v = CH_SPACE;
            4'd6:    v = CH_DASH;
            4'd7:    v = CH_DASH;
            4'd8:    v = CH_DOT;
            default: v = CH_QMARK;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] name_char(input logic [NAME_IDX_W-1:0] k,
                                             input logic [IDX_W-1:0] p);
        logic [47:0]      s;
        logic [IDX_W-1:0] l;
        s = name_str(k);
        l = name_len(k);
        if (p >= l) begin
            return 8'h00;
        end
        return s[8*int'(l - 4'd1 - p) +: 8];
    endfunction

    // numeric code point to latin-1 byte
    function automatic logic [7:0] map_code(input logic [31:0] cp);
        if (cp == 32'd160) return CH_SPACE;
        if (cp <= 32'hFF) return cp[7:0];
        if (cp == 32'd8211 || cp == 32'd8212) return CH_DASH;
        if (cp == 32'd8216 || cp == 32'd8217) return CH_APOS;
        if (cp == 32'd8220 || cp == 32'd8221) return CH_QUOTE;
        return CH_QMARK;
    endfunction

endpackage

FILE: rtl/hed_if.sv
// ----------------------------------------------------------------------------
// hed_in_if / hed_out_if
// Valid/ready channels for raw input bytes and decoded output bytes.
// ----------------------------------------------------------------------------
interface hed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       run_end;

    modport source (output valid, in_byte, run_end, input ready);
    modport sink   (input valid, in_byte, run_end, output ready);
endinterface

interface hed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       run_done;

    modport source (output valid, out_byte, out_last, run_done, input ready);
    modport sink   (input valid, out_byte, out_last, run_done, output ready);
endinterface

FILE: rtl/hed_ctrl.sv
// ----------------------------------------------------------------------------
// hed_ctrl
// Sequencer: walks the held bytes, scans entities and drives the datapath.
// ----------------------------------------------------------------------------
module hed_ctrl
    import hed_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_HEAD;
            end
            ST_HEAD: begin
                priority if (i_stat.len_zero) n_state = ST_FLUSH;
                else if (i_stat.head_amp) n_state = ST_SCAN;
                else if (i_stat.hold_utf) n_state = ST_FLUSH;
                else n_state = ST_HEAD;
            end
            ST_SCAN: begin
                priority if (i_stat.scan_out) begin
                    if (!i_stat.run_end) n_state = ST_FLUSH;
                    else if (i_stat.emit_ok) n_state = ST_HEAD;
                end else if (!i_stat.scan_term) begin
                    n_state = ST_SCAN;
                end else if (i_stat.emit_ok) begin
                    n_state = (i_stat.ent_hit && i_stat.ent_hellip) ? ST_DOT1 : ST_HEAD;
                end
            end
            ST_DOT1: begin
                if (i_stat.emit_ok) n_state = ST_DOT2;
            end
            ST_DOT2: begin
                if (i_stat.emit_ok) n_state = ST_HEAD;
            end
            ST_FLUSH: begin
                if (!i_stat.pend_valid || i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.esel = ES_HEAD;
        o_cmd.drop = DR_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            ST_HEAD: begin
                priority if (i_stat.len_zero) begin
                    o_cmd.emit = 1'b0;
                end else if (i_stat.head_amp) begin
                    o_cmd.scan_init = 1'b1;
                end else if (!i_stat.hold_utf && i_stat.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.esel = ES_HEAD;
                    o_cmd.drop = DR_NEED;
                end
            end
            ST_SCAN: begin
                priority if (i_stat.scan_out) begin
                    if (i_stat.run_end && i_stat.emit_ok) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.esel = ES_AMP;
                        o_cmd.drop = DR_ONE;
                    end
                end else if (!i_stat.scan_term) begin
                    o_cmd.scan_step = 1'b1;
                end else if (i_stat.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.ent_hit) begin
                        o_cmd.esel = ES_ENT;
                        o_cmd.drop = DR_ENT;
                    end else begin
                        o_cmd.esel = ES_AMP;
                        o_cmd.drop = DR_ONE;
                    end
                end
            end
            ST_DOT1, ST_DOT2: begin
                o_cmd.emit = i_stat.emit_ok;
                o_cmd.esel = ES_DOT;
            end
            ST_FLUSH: begin
                o_cmd.flush = i_stat.pend_valid && i_stat.out_free;
            end
            default: o_cmd.emit = 1'b0;
        endcase
    end

    // input is taken only between items
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == ST_IDLE)
        else $error("load outside idle");
    a_load_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ST_HEAD)
        else $error("load not followed by head");
    a_emit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.emit_ok && !o_cmd.flush)
        else $error("emit without room");

endmodule

FILE: rtl/hed_datapath.sv
// ----------------------------------------------------------------------------
// hed_datapath
// Byte buffer, entity scan accumulators, one-byte pending stage and the
// output register.
// ----------------------------------------------------------------------------
module hed_datapath
    import hed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [7:0] i_in_byte,
    input  logic       i_run_end,
    input  logic       i_out_ready,
    output t_stat      o_stat,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_run_done
);

    logic [7:0]           r_buf [WORK];
    logic [7:0]           n_buf [WORK];
    logic [IDX_W-1:0]     r_len, n_len;
    logic                 r_end;
    logic [IDX_W-1:0]     r_j;
    logic                 r_num, r_hex, r_bad;
    logic [31:0]          r_cp;
    logic [NUM_NAMES-1:0] r_match, n_match;
    logic                 r_pv, r_ov;
    logic [7:0]           r_pb;

    logic [7:0]       head, cj, cl, ebyte, utf_byte, ent_byte;
    logic [2:0]       need, need_eff;
    logic [20:0]      ucp;
    logic [IDX_W-1:0] p, shamt;
    logic [3:0]       dval;
    logic             is_dec, is_hexd, semi, term;
    logic [NUM_NAMES-1:0] hit;
    logic             out_free;

    // head byte classification
    always_comb begin
        head = r_buf[0];
        priority if (head[7:5] == 3'b110) need = 3'd2;
        else if (head[7:4] == 4'b1110) need = 3'd3;
        else if (head[7:3] == 5'b11110) need = 3'd4;
        else need = 3'd1;
        need_eff = ({1'b0, need} > r_len) ? 3'd1 : need;
        unique case (need_eff)
            3'd2: ucp = {10'd0, head[4:0], r_buf[1][5:0]};
            3'd3: ucp = {5'd0, head[3:0], r_buf[1][5:0], r_buf[2][5:0]};
            3'd4: ucp = {head[2:0], r_buf[1][5:0], r_buf[2][5:0], r_buf[3][5:0]};
            default: ucp = {13'd0, head};
        endcase
        utf_byte = (ucp <= 21'hFF) ? ucp[7:0] : CH_QMARK;
    end

    // scan byte and digit decode
    always_comb begin
        cj     = r_buf[r_j];
        cl     = to_lower(cj);
        p      = r_j - 4'd1;
        semi   = cj == CH_SEMI;
        term   = semi || (r_j > IDX_W'(MAX_NAME)) || is_stop(cj);
        is_dec = cj >= 8'h30 && cj <= 8'h39;
        is_hexd = is_dec || (cl >= 8'h61 && cl <= 8'h66);
        dval   = is_dec ? cj[3:0] : 4'(cl - 8'h57);
        for (int k = 0; k < NUM_NAMES; k++) begin
            n_match[k] = ((p == '0) ? 1'b1 : r_match[k]) &&
                         (p < name_len(NAME_IDX_W'(k))) &&
                         (cl == name_char(NAME_IDX_W'(k), p));
            hit[k] = r_match[k] && (name_len(NAME_IDX_W'(k)) == p);
        end
    end

    // entity result at the stop point
    always_comb begin
        ent_byte = CH_QMARK;
        if (r_num) begin
            ent_byte = map_code(r_cp);
        end else begin
            for (int k = NUM_NAMES - 1; k >= 0; k--) begin
                if (hit[k]) ent_byte = name_val(NAME_IDX_W'(k));
            end
        end
    end

    // emitted byte select
    always_comb begin
        unique case (i_cmd.esel)
            ES_HEAD: ebyte = head[7] ? utf_byte : head;
            ES_AMP:  ebyte = CH_AMP;
            ES_ENT:  ebyte = ent_byte;
            ES_DOT:  ebyte = CH_DOT;
            default: ebyte = CH_QMARK;
        endcase
    end

    // buffer load and consume
    always_comb begin
        unique case (i_cmd.drop)
            DR_NEED: shamt = IDX_W'(need_eff);
            DR_ONE:  shamt = IDX_W'(1);
            DR_ENT:  shamt = r_j + 4'd1;
            default: shamt = '0;
        endcase
        n_buf = r_buf;
        n_len = r_len - shamt;
        for (int k = 0; k < WORK; k++) begin
            if ((k + int'(shamt)) < WORK) begin
                n_buf[k] = r_buf[k + int'(shamt)];
            end
        end
        if (i_cmd.load) begin
            n_buf[r_len] = i_in_byte;
            n_len        = r_len + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= n_len;
        end
        r_buf <= n_buf;
        if (i_cmd.load) r_end <= i_run_end;
    end

    // entity scan accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_j <= IDX_W'(1);
        end else if (i_cmd.scan_step) begin
            r_j     <= r_j + 4'd1;
            r_match <= n_match;
            if (p == '0) begin
                r_num <= cj == CH_HASH;
                r_hex <= 1'b0;
                r_bad <= 1'b0;
                r_cp  <= '0;
            end else if (r_num) begin
                if (p == IDX_W'(1) && cl == 8'h78) begin
                    r_hex <= 1'b1;
                end else if (r_hex) begin
                    if (is_hexd) r_cp <= {r_cp[27:0], dval};
                    else r_bad <= 1'b1;
                end else begin
                    if (is_dec) r_cp <= {r_cp[28:0], 3'd0} + {r_cp[30:0], 1'b0}
                                        + {28'd0, dval};
                    else r_bad <= 1'b1;
                end
            end
        end
    end

    // pending byte and output register
    assign out_free = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_pb <= ebyte;
                r_pv <= 1'b1;
                if (r_pv) begin
                    o_out_byte <= r_pb;
                    o_out_last <= 1'b0;
                    o_run_done <= 1'b0;
                    r_ov       <= 1'b1;
                end else if (i_out_ready) begin
                    r_ov <= 1'b0;
                end
            end else if (i_cmd.flush) begin
                o_out_byte <= r_pb;
                o_out_last <= 1'b1;
                o_run_done <= r_end;
                r_ov       <= 1'b1;
                r_pv       <= 1'b0;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;

    // status to the sequencer
    always_comb begin
        o_stat            = '0;
        o_stat.len_zero   = r_len == '0;
        o_stat.head_amp   = head == CH_AMP;
        o_stat.hold_utf   = head[7] && need != 3'd1 && ({1'b0, need} > r_len) && !r_end;
        o_stat.scan_out   = r_j >= r_len;
        o_stat.scan_term  = term;
        o_stat.ent_hit    = semi && (p != '0) && (r_num ? !r_bad : (hit != '0));
        o_stat.ent_hellip = !r_num && hit[NUM_NAMES-1];
        o_stat.run_end    = r_end;
        o_stat.emit_ok    = !r_pv || out_free;
        o_stat.out_free   = out_free;
        o_stat.pend_valid = r_pv;
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= IDX_W'(WORK))
        else $error("buffer overrun");
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> !r_pv && r_ov && o_out_last)
        else $error("flush did not close the item");
    a_end_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.flush && r_end) |-> r_len == '0)
        else $error("bytes left after run end");

endmodule

FILE: rtl/html_entity_utf8_text_decoder_core.sv
// ----------------------------------------------------------------------------
// html_entity_utf8_text_decoder_core
// Decodes HTML entities and UTF-8 sequences of a text run into Latin-1 bytes.
// ----------------------------------------------------------------------------
// Sequence: from the accepting edge, every result byte, every '&' met and every
// entity name byte scanned is a step of its own (held bytes are scanned again on
// every new item), and the flush state then closes the item.
// Flow: one item at a time, the next accepted only after the item closes;
// output stalls hold the flow.
// Reset: synchronous active-low i_rst_n empties the buffer and both output
// stages; input is accepted as soon as reset is released.
module html_entity_utf8_text_decoder_core
    import hed_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    hed_in_if.sink    i_in,
    hed_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;

    hed_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hed_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_byte   (i_in.in_byte),
        .i_run_end   (i_in.run_end),
        .i_out_ready (o_out.ready),
        .o_stat      (stat),
        .o_out_valid (o_out.valid),
        .o_out_byte  (o_out.out_byte),
        .o_out_last  (o_out.out_last),
        .o_run_done  (o_out.run_done)
    );

endmodule
